// ===== sv/skgr_pkg.sv =====
// shared types and constants of the stream k-group reverser
// no dependencies; imported by skgr_ctrl, skgr_datapath and the top level
package skgr_pkg;

    localparam int MAX_GROUP  = 16;
    localparam int IDX_W      = $clog2(MAX_GROUP);
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int VALUE_W    = 32;
    localparam int GSIZE_W    = 5;
    localparam int CMP_W      = (CNT_W > GSIZE_W) ? CNT_W : GSIZE_W;
    localparam int GSIZE_RST  = 2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // write the incoming beat and decide on a flush
        logic read;     // fetch the next buffered entry into the output register
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic flush;    // the beat being accepted releases the buffered group
        logic more;     // entries of the current group still to be fetched
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } t_state;

endpackage

// ===== sv/stream_k_group_reverser.sv =====
// top level of the stream k-group reverser
// depends on skgr_pkg, skgr_ctrl and skgr_datapath
//
// Collects beats of a list into groups of group_size (1..16, reset 2; 0 acts
// as 1, larger values as 16) and sends each full group out newest first. A
// list whose last beat leaves a partial group sends that group out in arrival
// order. The final result of a list carries o_last_res. Beats of a group that
// is still filling are taken one per cycle. The beat that completes a group
// (or ends the list) is followed by the fetch state S_READ and then one result
// per cycle while i_out_ready is high. Input is held off during the drain
// because the next group would overwrite the one group buffer that is being
// read out. group_size is written by i_cfg_we/i_cfg_data and takes effect on
// the next beat; if the buffer then holds at least the new size, everything
// buffered goes out reversed.
module stream_k_group_reverser
    import skgr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write
    input  logic               i_cfg_we,
    input  logic [GSIZE_W-1:0] i_cfg_data,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [VALUE_W-1:0] o_value_res,
    output logic               o_last_res
);

    t_cmd cmd;
    t_sts sts;

    // sequencing: accept, fetch first entry, then stream out the group
    skgr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // buffer, counters and the output register
    skgr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res)
    );

endmodule

// ===== sv/skgr_ctrl.sv =====
// control state machine of the stream k-group reverser
// depends on skgr_pkg; drives t_cmd into skgr_datapath and reads back t_sts
module skgr_ctrl
    import skgr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);

    t_state r_state;
    t_state n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SEND);

    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.read   = (r_state == S_READ) ||
                       ((r_state == S_SEND) && i_out_ready && i_sts.more);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.flush) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_out_ready && !i_sts.more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a fetch is always followed by send, with the fetched entry in the output register
    a_read_to_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_SEND))
        else $error("fetch not followed by send");

    // a stalled result keeps the machine in send
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SEND) && !i_out_ready) |=> (r_state == S_SEND))
        else $error("stalled result dropped");

    // never write a new beat while draining
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> !o_cmd.read)
        else $error("accept and fetch in the same cycle");

endmodule

// ===== sv/skgr_datapath.sv =====
// group buffer, fill and drain counters and output register
// depends on skgr_pkg; commanded by skgr_ctrl
module skgr_datapath
    import skgr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [GSIZE_W-1:0] i_cfg_data,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_last,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic [VALUE_W-1:0] o_value_res,
    output logic               o_last_res
);

    logic [VALUE_W-1:0] r_mem [MAX_GROUP];

    logic [GSIZE_W-1:0] r_gsize;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_left;
    logic [IDX_W-1:0]   r_idx;
    logic               r_rev;
    logic               r_end;
    logic [VALUE_W-1:0] r_rd_data;
    logic               r_last_out;

    logic [CNT_W-1:0]   k_eff;
    logic [IDX_W-1:0]   wr_ptr;
    logic [CNT_W-1:0]   n_cnt;
    logic               full_grp;

    // clamp the group size into 1..MAX_GROUP
    always_comb begin
        if (r_gsize == '0) begin
            k_eff = CNT_W'(1);
        end else if (CMP_W'(r_gsize) > CMP_W'(MAX_GROUP)) begin
            k_eff = CNT_W'(MAX_GROUP);
        end else begin
            k_eff = CNT_W'(r_gsize);
        end
    end

    always_comb begin
        if (r_fill >= CNT_W'(MAX_GROUP)) begin
            wr_ptr = IDX_W'(MAX_GROUP - 1);
        end else begin
            wr_ptr = r_fill[IDX_W-1:0];
        end
        n_cnt    = CNT_W'(wr_ptr) + CNT_W'(1);
        full_grp = (n_cnt >= k_eff);
    end

    assign o_sts.flush = full_grp || i_last;
    assign o_sts.more  = (r_left != '0);

    assign o_value_res = r_rd_data;
    assign o_last_res  = r_last_out;

    // buffer storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[wr_ptr] <= i_value;
        end
        if (i_cmd.read) begin
            r_rd_data  <= r_mem[r_idx];
            r_last_out <= r_end && (r_left == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsize <= GSIZE_W'(GSIZE_RST);
            r_fill  <= '0;
            r_left  <= '0;
            r_idx   <= '0;
            r_rev   <= 1'b0;
            r_end   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gsize <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (full_grp || i_last) begin
                    r_fill <= '0;
                    r_left <= n_cnt;
                    r_rev  <= full_grp;
                    r_end  <= i_last;
                    r_idx  <= full_grp ? wr_ptr : '0;
                end else begin
                    r_fill <= n_cnt;
                end
            end else if (i_cmd.read) begin
                r_left <= r_left - CNT_W'(1);
                r_idx  <= r_rev ? (r_idx - IDX_W'(1)) : (r_idx + IDX_W'(1));
            end
        end
    end

    // a partial group always stays below the buffer depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < CNT_W'(MAX_GROUP))
        else $error("fill count beyond buffer depth");

endmodule
